@@ src/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Blade pitch controller package
// Shared widths, opcodes, register indexes and the controller/datapath
// command and status types.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Field widths
  localparam int SPEED_W   = 20;
  localparam int LIMIT_W   = 16;
  localparam int POS_W     = 24;
  localparam int GAIN_W    = 24;
  localparam int WEIGHT_W  = 17;
  localparam int ANGLE_W   = 24;
  localparam int CFG_W     = 24;
  localparam int REG_IDX_W = 3;

  // Fixed-point scaling
  localparam int GAIN_FRAC_BITS   = 16;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;

  // Opcodes
  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_CONTROL = 2'd2;
  localparam logic [1:0] OP_STOP    = 2'd3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BEST   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GPROP  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GRATE  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT = 3'd6;

  // Reset values
  localparam logic [LIMIT_W-1:0] RST_LOW  = 16'd0;
  localparam logic [LIMIT_W-1:0] RST_HIGH = 16'd46080;
  localparam logic [LIMIT_W-1:0] RST_BEST = 16'd23040;

  // Angle divider: magnitude of dividend padded to a whole number of steps
  localparam int DIV_W      = 44;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_ITER   = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER + 1);

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic upd;
    logic mapm;
    logic div_start;
    logic out_load;
  } bpc_cmd_t;

  typedef struct packed {
    logic div_done;
  } bpc_stat_t;

endpackage

@@ src/bpc_div.sv @@
// ----------------------------------------------------------------------------
// Blade pitch controller angle divider
// Unsigned restoring divider, DIV_STEPS quotient bits per cycle.
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [LIMIT_W-1:0] divisor,
  output logic               done,
  output logic [DIV_W-1:0]   quotient
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quot_r;
  logic [LIMIT_W-1:0]   rem_r;
  logic [LIMIT_W-1:0]   dsr_r;
  logic [DIV_W-1:0]     q_next;
  logic [LIMIT_W-1:0]   rem_next;
  logic [LIMIT_W:0]     trial;

  always_comb begin
    q_next   = quot_r;
    rem_next = rem_r;
    trial    = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial  = {rem_next, q_next[DIV_W-1]};
      q_next = {q_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        trial     = trial - {1'b0, dsr_r};
        q_next[0] = 1'b1;
      end
      rem_next = trial[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_ITER);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (cnt != '0) begin
      quot_r <= q_next;
      rem_r  <= rem_next;
    end
  end

  assign done     = (cnt == DIV_CNT_W'(1));
  assign quotient = quot_r;

endmodule

@@ src/bpc_dpath.sv @@
// ----------------------------------------------------------------------------
// Blade pitch controller datapath
// Registers, position update arithmetic and pitch angle mapping.
// ----------------------------------------------------------------------------
module bpc_dpath import bpc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [REG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic [1:0]                in_opcode,
  input  logic [SPEED_W-1:0]        in_now,
  input  logic [SPEED_W-1:0]        in_before,
  input  bpc_cmd_t                  cmd,
  output bpc_stat_t                 stat,
  output logic                      res_write,
  output logic [LIMIT_W-1:0]        res_command,
  output logic signed [ANGLE_W-1:0] res_angle
);

  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int NP_W   = ACC_W + 1;
  localparam int MAP_W  = 42;
  localparam int SPAN_W = LIMIT_W + 1;
  localparam int QS_W   = DIV_W + 2;
  localparam logic signed [ACC_W-1:0] RND_GAIN  = ACC_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RND_START = ACC_W'(1) << (WEIGHT_FRAC_BITS - 1);
  localparam logic signed [NP_W-1:0]  POS_MAX_X = NP_W'({POS_W{1'b1}});
  localparam logic signed [QS_W-1:0]  ANG_MAX   = QS_W'({1'b0, {(ANGLE_W-1){1'b1}}});
  localparam logic signed [QS_W-1:0]  ANG_MIN   = -(QS_W'(1) << (ANGLE_W - 1));

  // Configuration
  logic [LIMIT_W-1:0]       low;
  logic [LIMIT_W-1:0]       high;
  logic [LIMIT_W-1:0]       best;
  logic [SPEED_W-1:0]       target;
  logic signed [GAIN_W-1:0] gp;
  logic signed [GAIN_W-1:0] gr;
  logic [WEIGHT_W-1:0]      weight;

  // Item and state
  logic [1:0]               op_r;
  logic [SPEED_W-1:0]       now_r;
  logic [SPEED_W-1:0]       before_r;
  logic [POS_W-1:0]         pos_r;
  logic                     wr_r;

  logic [WEIGHT_W-1:0]      w_sat;
  logic signed [SPEED_W:0]  err;
  logic signed [SPEED_W:0]  dlt;
  logic signed [MUL_W-1:0]  a1, a2, b1, b2;
  logic signed [PROD_W-1:0] prod_a, prod_b;
  logic signed [ACC_W-1:0]  pa_x, pb_x, acc;
  logic signed [ACC_W-1:0]  corr;
  logic signed [NP_W-1:0]   pos_x, low_x, high_x, np;
  logic                     take;
  logic                     in_lim;
  logic [POS_W-1:0]         pos_sat;

  logic signed [MUL_W-1:0]  diff;
  logic signed [SPAN_W-1:0] neg_lo;
  logic signed [MAP_W-1:0]  map_prod;
  logic signed [SPAN_W-1:0] span_r;
  logic [MAP_W-1:0]         prod_mag;
  logic [SPAN_W-1:0]        span_mag;
  logic                     q_neg_r;
  logic [DIV_W-1:0]         quot;
  logic signed [QS_W-1:0]   q_s;
  logic signed [QS_W-1:0]   ang_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      low    <= RST_LOW;
      high   <= RST_HIGH;
      best   <= RST_BEST;
      target <= '0;
      gp     <= '0;
      gr     <= '0;
      weight <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW:    low    <= cfg_data[LIMIT_W-1:0];
        REG_HIGH:   high   <= cfg_data[LIMIT_W-1:0];
        REG_BEST:   best   <= cfg_data[LIMIT_W-1:0];
        REG_TARGET: target <= cfg_data[SPEED_W-1:0];
        REG_GPROP:  gp     <= cfg_data[GAIN_W-1:0];
        REG_GRATE:  gr     <= cfg_data[GAIN_W-1:0];
        REG_WEIGHT: weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      now_r    <= in_now;
      before_r <= in_before;
    end
  end

  // Multiply: gains on speed terms, or smoothing weights on positions
  always_comb begin
    w_sat = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    err   = $signed({1'b0, target}) - $signed({1'b0, now_r});
    dlt   = $signed({1'b0, now_r}) - $signed({1'b0, before_r});
    if (op_r == OP_CONTROL) begin
      a1 = {{(MUL_W-SPEED_W-1){err[SPEED_W]}}, err};
      a2 = {gp[GAIN_W-1], gp};
      b1 = {{(MUL_W-SPEED_W-1){dlt[SPEED_W]}}, dlt};
      b2 = {gr[GAIN_W-1], gr};
    end else begin
      a1 = {{(MUL_W-WEIGHT_W){1'b0}}, w_sat};
      a2 = {1'b0, pos_r};
      b1 = {{(MUL_W-WEIGHT_W){1'b0}}, WEIGHT_ONE - w_sat};
      b2 = {{(MUL_W-LIMIT_W){1'b0}}, best};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_a <= a1 * a2;
      prod_b <= b1 * b2;
    end
  end

  // Accumulate with rounding offset
  assign pa_x = {prod_a[PROD_W-1], prod_a};
  assign pb_x = {prod_b[PROD_W-1], prod_b};

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      acc <= (op_r == OP_CONTROL) ? pa_x - pb_x + RND_GAIN : pa_x + pb_x + RND_START;
    end
  end

  // New position, acceptance and saturation
  always_comb begin
    corr   = acc >>> GAIN_FRAC_BITS;
    pos_x  = $signed({{(NP_W-POS_W){1'b0}}, pos_r});
    low_x  = $signed({{(NP_W-LIMIT_W){1'b0}}, low});
    high_x = $signed({{(NP_W-LIMIT_W){1'b0}}, high});
    take   = 1'b1;
    case (op_r)
      OP_INIT:  np = low_x;
      OP_START: np = $signed({{(NP_W-POS_W){1'b0}},
                              acc[WEIGHT_FRAC_BITS+POS_W-1:WEIGHT_FRAC_BITS]});
      OP_CONTROL: begin
        np   = pos_x + {corr[ACC_W-1], corr};
        take = (now_r >= before_r) ? (np >= low_x) : (np <= high_x);
      end
      default:  np = high_x;
    endcase
    in_lim = (np >= low_x) && (np <= high_x);
    if (np < 0) begin
      pos_sat = '0;
    end else if (np > POS_MAX_X) begin
      pos_sat = {POS_W{1'b1}};
    end else begin
      pos_sat = np[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_r <= POS_W'(RST_HIGH);
    end else if (cmd.upd && take) begin
      pos_r <= pos_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      wr_r <= take && in_lim;
    end
  end

  // Angle mapping: (P-L)*(-L) / (H-L) + L
  assign diff   = $signed({1'b0, pos_r}) - $signed({{(MUL_W-LIMIT_W){1'b0}}, low});
  assign neg_lo = -$signed({1'b0, low});

  always_ff @(posedge clk) begin
    if (cmd.mapm) begin
      map_prod <= diff * neg_lo;
      span_r   <= $signed({1'b0, high}) - $signed({1'b0, low});
    end
  end

  assign prod_mag = map_prod[MAP_W-1] ? MAP_W'(-map_prod) : MAP_W'(map_prod);
  assign span_mag = span_r[SPAN_W-1] ? SPAN_W'(-span_r) : SPAN_W'(span_r);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_neg_r <= map_prod[MAP_W-1] ^ span_r[SPAN_W-1];
    end
  end

  bpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({{(DIV_W-MAP_W){1'b0}}, prod_mag}),
    .divisor  (span_mag[LIMIT_W-1:0]),
    .done     (stat.div_done),
    .quotient (quot)
  );

  // Sign, offset and clamp the quotient
  always_comb begin
    q_s      = q_neg_r ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    ang_full = q_s + $signed({{(QS_W-LIMIT_W){1'b0}}, low});
    if (span_r == '0) begin
      res_angle = $signed({{(ANGLE_W-LIMIT_W){1'b0}}, low});
    end else if (ang_full > ANG_MAX) begin
      res_angle = ANG_MAX[ANGLE_W-1:0];
    end else if (ang_full < ANG_MIN) begin
      res_angle = ANG_MIN[ANGLE_W-1:0];
    end else begin
      res_angle = ang_full[ANGLE_W-1:0];
    end
  end

  assign res_write   = wr_r;
  assign res_command = wr_r ? pos_r[LIMIT_W-1:0] : '0;

endmodule

@@ src/bpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Blade pitch controller sequencer
// Steps one command word through multiply, update, mapping and divide.
// ----------------------------------------------------------------------------
module bpc_ctrl import bpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_free,
  input  bpc_stat_t stat,
  output bpc_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_MAPM = 3'd4;
  localparam logic [2:0] ST_DLD  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_MAPM;
      ST_MAPM: state_next = ST_DLD;
      ST_DLD:  state_next = ST_DIV;
      ST_DIV:  if (stat.div_done) state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready      = (state == ST_IDLE);
  assign cmd.load      = (state == ST_IDLE) && in_valid;
  assign cmd.mul       = (state == ST_MUL);
  assign cmd.sum       = (state == ST_SUM);
  assign cmd.upd       = (state == ST_UPD);
  assign cmd.mapm      = (state == ST_MAPM);
  assign cmd.div_start = (state == ST_DLD);
  assign cmd.out_load  = (state == ST_FIN) && out_free;

endmodule

@@ src/blade_pitch_controller_core.sv @@
// ----------------------------------------------------------------------------
// Blade pitch controller core
// Servo position controller with smoothing, speed control and limits.
// ----------------------------------------------------------------------------
// One command word per control tick gives one result word. Each word is taken
// in the idle state and then runs through a fixed sequence: multiplies,
// accumulation, position update, the mapping product, loading the divider and
// the divider steps (four quotient bits a cycle on a 44-bit magnitude), then
// the result is handed to the output register. The result register lets the
// next word in while the previous result still waits downstream. Configuration
// writes are always accepted (cfg_ready tied high) and should only be made
// while no word is in flight. The servo position resets to the high limit
// reset value.
module blade_pitch_controller_core import bpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // command stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // [19:0] speed_now, [39:20] speed_before
  input  logic [1:0]           s_tuser,   // [1:0] opcode
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // [15:0] servo_command, [39:16] pitch_angle
  output logic [0:0]           m_tuser,   // [0] servo_write
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  bpc_cmd_t                  cmd;
  bpc_stat_t                 stat;
  logic                      out_free;
  logic                      res_write;
  logic [LIMIT_W-1:0]        res_command;
  logic signed [ANGLE_W-1:0] res_angle;

  // Registers are always writable; the datapath decodes the index.
  assign cfg_ready = 1'b1;

  // Output slot is free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;

  bpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpc_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_opcode   (s_tuser),
    .in_now      (s_tdata[SPEED_W-1:0]),
    .in_before   (s_tdata[2*SPEED_W-1:SPEED_W]),
    .cmd         (cmd),
    .stat        (stat),
    .res_write   (res_write),
    .res_command (res_command),
    .res_angle   (res_angle)
  );

  // Result register: hold the word until taken, load when the slot frees.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {res_angle, res_command};
      m_tuser <= res_write;
    end
  end

endmodule

@@ src/bpc_chk.sv @@
// ----------------------------------------------------------------------------
// Blade pitch controller port checker
// Watches the core's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module bpc_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // One word in flight: no acceptance right after another.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command accepted on consecutive cycles");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // No servo write means a zero command.
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0)
    else $error("servo command set without servo write");

  // Reset leaves the core empty and ready.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("core not idle after reset");

endmodule

bind blade_pitch_controller_core bpc_chk u_bpc_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
